### design/sfmw_pkg.sv
// ----------------------------------------------------------------------------
// Span fill mask writer package
// Shared constants, controller states and the command and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sfmw_pkg;

	// Pixels covered by one fill command.
	localparam int unsigned GROUP_PIXELS = 32;
	localparam int unsigned GROUP_BITS   = $clog2(GROUP_PIXELS);

	// Widest line that the address and clipping logic honor.
	localparam logic [11:0] MAX_LINE_WIDTH = 12'd2048;

	// Register reset values.
	localparam logic [31:0] FILL_BASE_RESET  = 32'h0000_0000;
	localparam logic [11:0] LINE_WIDTH_RESET = 12'd1152;

	// Register indexes on the write port.
	localparam logic REG_FILL_BASE  = 1'b0;
	localparam logic REG_LINE_WIDTH = 1'b1;

	// Command word fields.
	localparam logic [3:0]  OP_COPY       = 4'h3;
	localparam logic [31:0] MODE_8_MAPPED = 32'h0000_0000;
	localparam logic [31:0] FULL_MASK     = 32'hffff_ffff;

	// Address advance from one group to the next: eight bytes per pixel.
	localparam logic [31:0] ADDR_STEP = 32'd256;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} sfmw_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;   // take the input item into the work registers
		logic calc;      // clip the span and form the first address
		logic load;      // load the next command into the output register
	} sfmw_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;     // the span writes no pixel
		logic last;      // the next command is the final one of the span
		logic out_full;  // the output register holds a command
	} sfmw_status_t;

endpackage

### design/sfmw_ctrl.sv
// ----------------------------------------------------------------------------
// Span fill mask writer controller
// Sequences one span at a time: capture, setup, then one command per cycle
// while the output register can take it.
// ----------------------------------------------------------------------------
module sfmw_ctrl
	import sfmw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         out_stall,
	input  sfmw_status_t status,
	output sfmw_cmd_t    cmd
);

	sfmw_state_t state_q;
	sfmw_state_t state_d;
	logic        out_free;
	logic        take_in;

	// The output register can be loaded when empty or being emptied.
	assign out_free = !status.out_full || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = status.empty ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && status.last) begin
					state_d = in_valid ? ST_CALC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs. A new item may enter while the final command is loaded.
	always_comb begin
		take_in     = 1'b0;
		cmd.calc    = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take_in = 1'b1;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_EMIT: begin
				cmd.load = out_free;
				take_in  = out_free && status.last;
			end
			default: begin
				take_in = 1'b0;
			end
		endcase
		in_stall    = !take_in;
		cmd.capture = take_in && in_valid;
	end

	// A span in setup never takes a second item.
	a_no_capture_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !cmd.capture)
		else $error("item captured during setup");

	// Emission ends only on the final command.
	a_emit_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_d != ST_EMIT) |-> (cmd.load && status.last))
		else $error("emission left before the final command");

endmodule

### design/sfmw_dp.sv
// ----------------------------------------------------------------------------
// Span fill mask writer datapath
// Holds the registers, clips the span, forms the address and builds the
// write mask of each 32-pixel group into the output register.
// ----------------------------------------------------------------------------
module sfmw_dp
	import sfmw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic         wr_index,
	input  logic [31:0]  wr_data,
	input  logic [10:0]  start_x,
	input  logic [10:0]  line_y,
	input  logic [11:0]  pixel_count,
	input  logic [7:0]   fill_color,
	input  logic         out_stall,
	input  sfmw_cmd_t    cmd,
	output sfmw_status_t status,
	output logic         out_valid,
	output logic [31:0]  write_addr,
	output logic [63:0]  write_word,
	output logic         last_word
);

	logic [31:0] fill_base_q;
	logic [11:0] line_width_q;

	logic [10:0] x_q;
	logic [10:0] y_q;
	logic [11:0] cnt_q;
	logic [7:0]  color_q;

	logic [31:0] addr_q;
	logic [11:0] rem_q;
	logic [GROUP_BITS-1:0] left_q;

	logic        out_valid_q;
	logic [31:0] write_addr_q;
	logic [63:0] write_word_q;
	logic        last_word_q;

	logic [11:0] w_eff;
	logic [11:0] x_ext;
	logic [11:0] room;
	logic        empty;
	logic [11:0] rem_clip;
	logic [22:0] prod;
	logic [22:0] lin;
	logic [31:0] addr_first;

	logic [5:0]  take_max;
	logic        is_last;
	logic [5:0]  take;
	logic [5:0]  right;
	logic [31:0] mask;
	logic [31:0] upper;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_base_q  <= FILL_BASE_RESET;
			line_width_q <= LINE_WIDTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FILL_BASE:  fill_base_q  <= wr_data;
				REG_LINE_WIDTH: line_width_q <= wr_data[11:0];
				default:        fill_base_q  <= fill_base_q;
			endcase
		end
	end

	// Setup: effective width, clipping and the address of the first group.
	always_comb begin
		w_eff      = (line_width_q > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : line_width_q;
		x_ext      = {1'b0, x_q};
		empty      = (cnt_q == 12'd0) || (x_ext >= w_eff);
		room       = w_eff - x_ext;
		rem_clip   = (cnt_q > room) ? room : cnt_q;
		prod       = 23'(y_q) * 23'(w_eff);
		lin        = prod + 23'({x_q[10:GROUP_BITS], {GROUP_BITS{1'b0}}});
		addr_first = fill_base_q + {6'b0, lin, 3'b000};
	end

	// Per group: pixels taken and the write mask, leftmost pixel in bit 31.
	always_comb begin
		take_max = 6'(GROUP_PIXELS) - {1'b0, left_q};
		is_last  = rem_q <= {6'b0, take_max};
		take     = is_last ? rem_q[5:0] : take_max;
		right    = 6'(GROUP_PIXELS) - {1'b0, left_q} - take;
		mask     = (FULL_MASK >> left_q) & ~((32'd1 << right[4:0]) - 32'd1);
		upper    = ({28'b0, OP_COPY} << 28) | MODE_8_MAPPED | {24'b0, color_q};
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q     <= start_x;
			y_q     <= line_y;
			cnt_q   <= pixel_count;
			color_q <= fill_color;
		end
	end

	// Walk state: next address, pixels left and offset in the group.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr_q <= addr_first;
			rem_q  <= rem_clip;
			left_q <= x_q[GROUP_BITS-1:0];
		end else if (cmd.load) begin
			addr_q <= addr_q + ADDR_STEP;
			rem_q  <= rem_q - {6'b0, take};
			left_q <= '0;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			write_addr_q <= addr_q;
			write_word_q <= {upper, mask};
			last_word_q  <= is_last;
		end
	end

	assign status.empty    = empty;
	assign status.last     = is_last;
	assign status.out_full = out_valid_q;

	assign out_valid  = out_valid_q;
	assign write_addr = write_addr_q;
	assign write_word = write_word_q;
	assign last_word  = last_word_q;

	// A load always presents a command in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded command not presented");

	// A span that is not empty starts with pixels left to write.
	a_setup_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.calc && !empty) |=> (rem_q != 12'd0))
		else $error("span setup left no pixels");

	// A command that is not the final one leaves pixels for the next.
	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !is_last) |=> (rem_q != 12'd0))
		else $error("span ran out before its final command");

endmodule

### design/span_fill_mask_writer.sv
// ----------------------------------------------------------------------------
// Span fill mask writer
// Turns a horizontal span request into fill commands, one per aligned
// 32-pixel group that the span touches.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one span item: start_x, line_y,
//   pixel_count, fill_color. Output channel (out_valid / out_stall) gives one
//   command per group: write_addr, write_word, last_word. last_word marks the
//   final command of a span. A span with zero count, or starting at or past
//   the line end, gives no command; a span that runs past the end is clipped.
//   The user sets fill_base and line_width through wr_en / wr_index / wr_data
//   while the block is idle; the block itself does not enforce this.
// Timing:
//   After an item is accepted into the capture registers, the setup state
//   clips the span and forms the first address through the y * width
//   multiplier; then one command is loaded per cycle into the output
//   register while it can take one. The next item is accepted in the cycle
//   the final command is loaded; an empty span goes back to idle after setup.
// Reset and stall:
//   Reset empties the output register and restores fill_base = 0 and
//   line_width = 1152. A stalled command holds; the walk waits behind it.
// ----------------------------------------------------------------------------
module span_fill_mask_writer
	import sfmw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [10:0] start_x,
	input  logic [10:0] line_y,
	input  logic [11:0] pixel_count,
	input  logic [7:0]  fill_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] write_addr,
	output logic [63:0] write_word,
	output logic        last_word
);

	sfmw_cmd_t    cmd;
	sfmw_status_t status;

	// Span sequencer.
	sfmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Address, mask and output register.
	sfmw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.start_x     (start_x),
		.line_y      (line_y),
		.pixel_count (pixel_count),
		.fill_color  (fill_color),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.write_addr  (write_addr),
		.write_word  (write_word),
		.last_word   (last_word)
	);

endmodule

### sim/span_fill_mask_writer_tb.sv
// ----------------------------------------------------------------------------
// Span fill mask writer testbench
// Feeds span items through the valid/stall input channel and checks each fill
// command that leaves the output channel against a local predictor. The
// predictor keeps its own copy of fill_base and line_width. The run covers
// the reset settings, the widest line, a one-group line, a line width that is
// not a multiple of 32, and a wrapping base address. The sender works in
// bursts with gaps and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module span_fill_mask_writer_tb;
	import sfmw_pkg::*;

	// One span request as it goes onto the input channel.
	typedef struct {
		logic [10:0] x;
		logic [10:0] y;
		logic [11:0] cnt;
		logic [7:0]  color;
	} span_t;

	// One fill command as it should leave the block.
	typedef struct {
		logic [31:0] addr;
		logic [63:0] word;
		logic        last;
	} fill_cmd_t;

	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 6;

	logic        clk;
	logic        arst_n;
	logic        wr_en = 1'b0;
	logic        wr_index = REG_FILL_BASE;
	logic [31:0] wr_data = 32'h0;
	logic        in_valid;
	logic        in_stall;
	logic [10:0] start_x;
	logic [10:0] line_y;
	logic [11:0] pixel_count;
	logic [7:0]  fill_color;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] write_addr;
	logic [63:0] write_word;
	logic        last_word;

	// Local copy of the registers, in step with every write.
	logic [31:0] base_shadow = 32'h0000_0000;
	logic [11:0] width_shadow = 12'd1152;

	span_t     span_q[$];
	fill_cmd_t fill_cmd_q[$];
	span_t     drv_next;
	fill_cmd_t cmd_want;

	int  err_count = 0;
	int  idle_cycles = 0;
	int  burst_left;
	int  gap_left;
	bit  quiet_sender = 1'b0;
	int  stall_mode;
	int  mode_cycles;
	int  stall_run;

	span_fill_mask_writer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.line_y     (line_y),
		.pixel_count(pixel_count),
		.fill_color (fill_color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.write_addr (write_addr),
		.write_word (write_word),
		.last_word  (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Effective line width: the register clipped to the widest supported line.
	function automatic logic [11:0] eff_width();
		return (width_shadow > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width_shadow;
	endfunction

	// Work out the fill commands of one span and queue them in order.
	function automatic void predict_fill_commands(input span_t s);
		logic [11:0] w;
		logic [11:0] remain;
		logic [11:0] pos;
		logic [5:0]  left;
		logic [5:0]  take;
		logic [5:0]  right;
		logic [31:0] addr;
		logic [31:0] upper;
		logic [63:0] mask;
		fill_cmd_t   c;
		w = eff_width();
		if (s.cnt == 12'd0 || {1'b0, s.x} >= w)
			return;
		remain = s.cnt;
		if (remain > w - {1'b0, s.x})
			remain = w - {1'b0, s.x};
		upper = {OP_COPY, 28'h0} | MODE_8_MAPPED | {24'h0, s.color};
		pos = {1'b0, s.x};
		addr = base_shadow + ((32'(s.y) * 32'(w) + 32'({s.x[10:5], 5'b0})) << 3);
		while (remain != 12'd0) begin
			left = {1'b0, pos[4:0]};
			take = 6'd32 - left;
			if ({6'd0, take} > remain)
				take = remain[5:0];
			remain = remain - {6'd0, take};
			right = 6'd32 - left - take;
			mask = 64'hffff_ffff >> left;
			mask = mask & ~((64'd1 << right) - 64'd1);
			c.addr = addr;
			c.word = {upper, mask[31:0]};
			c.last = (remain == 12'd0);
			fill_cmd_q.push_back(c);
			pos = pos - {6'd0, left} + 12'd32;
			addr = addr + 32'd256;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= 50)
			$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	// Gap after a burst; none while the sender is told to stay busy.
	function automatic int pick_gap();
		if (quiet_sender || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Input driver: bursts of items from span_q with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			start_x <= '0;
			line_y <= '0;
			pixel_count <= '0;
			fill_color <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (span_q.size() != 0) begin
				drv_next = span_q.pop_front();
				in_valid <= 1'b1;
				start_x <= drv_next.x;
				line_y <= drv_next.y;
				pixel_count <= drv_next.cnt;
				fill_color <= drv_next.color;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= pick_gap();
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall: a random pattern, redrawn when its mode counter runs out: none, random, periodic or random runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			mode_cycles <= 0;
			stall_run <= 0;
		end else begin
			if (mode_cycles == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_cycles <= $urandom_range(20, 80);
			end else begin
				mode_cycles <= mode_cycles - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= (mode_cycles % 3 == 0);
				default: begin
					if (stall_run > 0) begin
						stall_run <= stall_run - 1;
						out_stall <= 1'b1;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_run <= $urandom_range(2, 8);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// Predict on each accepted item and check each accepted command.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_fill_commands('{start_x, line_y, pixel_count, fill_color});
			if (out_valid && !out_stall) begin
				if (fill_cmd_q.size() == 0) begin
					report_mismatch("unexpected command, addr", write_addr, 64'h0);
				end else begin
					cmd_want = fill_cmd_q.pop_front();
					if (write_addr !== cmd_want.addr)
						report_mismatch("write_addr", write_addr, cmd_want.addr);
					if (write_word !== cmd_want.word)
						report_mismatch("write_word", write_word, cmd_want.word);
					if (last_word !== cmd_want.last)
						report_mismatch("last_word", last_word, cmd_want.last);
				end
			end
		end
	end

	// Watchdog: too long without any accepted item, command or write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("span_fill_mask_writer_tb: errors");
				$finish;
			end
		end
	end

	// Register write while the block is idle; the shadow copy follows.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx == REG_FILL_BASE)
			base_shadow = val;
		else
			width_shadow = val[11:0];
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_span(input int x, input int y, input int cnt, input int color);
		span_t s;
		s.x = x[10:0];
		s.y = y[10:0];
		s.cnt = cnt[11:0];
		s.color = color[7:0];
		span_q.push_back(s);
	endtask

	// Random spans: mostly short console spans on the line, some anywhere.
	task automatic add_random_spans(input int n);
		int w;
		int x;
		int cnt;
		int pick;
		w = eff_width();
		repeat (n) begin
			x = ($urandom_range(0, 9) < 7) ? $urandom_range(0, w - 1) : $urandom_range(0, 2047);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				cnt = 0;
			else if (pick < 6)
				cnt = $urandom_range(1, 40);
			else if (pick < 8)
				cnt = $urandom_range(1, 200);
			else
				cnt = $urandom_range(0, 2048);
			add_span(x, $urandom_range(0, 2047), cnt, $urandom_range(0, 255));
		end
	endtask

	// Wait until every item is taken and every command has come out.
	task automatic wait_until_drained();
		while (span_q.size() != 0 || in_valid || fill_cmd_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: edges of each group, clipping and empty spans.
		quiet_sender = 1'b1;
		add_span(0, 0, 0, 8'h00);
		add_span(0, 0, 1, 8'h00);
		add_span(31, 1, 1, 8'hff);
		add_span(0, 2, 32, 8'h5a);
		add_span(0, 3, 33, 8'ha5);
		add_span(5, 4, 20, 8'h01);
		add_span(33, 9, 30, 8'h42);
		add_span(30, 5, 4, 8'h80);
		add_span(1151, 6, 1, 8'h7f);
		add_span(1152, 7, 5, 8'h10);
		add_span(2047, 2047, 2048, 8'hff);
		add_span(0, 2047, 2048, 8'hc3);
		add_span(1100, 100, 100, 8'h3c);
		add_span(17, 1023, 1152, 8'h99);
		add_span(1120, 1024, 32, 8'h66);
		add_span(64, 512, 2047, 8'hee);
		wait_until_drained();
		quiet_sender = 1'b0;
		add_random_spans(30);
		wait_until_drained();

		// Widest line with a base that wraps; the longest spans.
		write_reg(REG_LINE_WIDTH, {20'($urandom_range(0, 20'hfffff)), 12'd2048});
		write_reg(REG_FILL_BASE, 32'hffff_ff00);
		quiet_sender = 1'b1;
		add_span(0, 2047, 2048, 8'h81);
		add_span(2047, 0, 2048, 8'h18);
		add_span(1, 1, 2047, 8'hf0);
		add_span(2016, 5, 32, 8'h0f);
		add_random_spans(30);
		wait_until_drained();
		quiet_sender = 1'b0;

		// One-group line of 32 pixels, base of all ones.
		write_reg(REG_LINE_WIDTH, 32'd32);
		write_reg(REG_FILL_BASE, 32'hffff_ffff);
		add_span(0, 0, 32, 8'h11);
		add_span(31, 2047, 5, 8'h22);
		add_span(32, 1, 1, 8'h33);
		add_span(0, 5, 0, 8'h44);
		add_random_spans(30);
		wait_until_drained();

		// A line width that is not a multiple of 32.
		write_reg(REG_LINE_WIDTH, {20'($urandom_range(0, 20'hfffff)), 12'd1000});
		write_reg(REG_FILL_BASE, $urandom);
		add_span(990, 3, 100, 8'h55);
		add_random_spans(30);
		wait_until_drained();

		// Random width; the sender holds off mid-phase until all is out.
		write_reg(REG_LINE_WIDTH, $urandom_range(1, 64) * 32);
		write_reg(REG_FILL_BASE, $urandom);
		add_random_spans(15);
		wait_until_drained();
		add_random_spans(15);
		wait_until_drained();

		// Back to the reset settings.
		write_reg(REG_LINE_WIDTH, 32'd1152);
		write_reg(REG_FILL_BASE, 32'h0);
		add_random_spans(30);
		wait_until_drained();

		if (err_count == 0)
			$display("span_fill_mask_writer_tb: clean");
		else
			$display("span_fill_mask_writer_tb: errors");
		$finish;
	end

endmodule

### filelist.f
design/sfmw_pkg.sv
design/sfmw_ctrl.sv
design/sfmw_dp.sv
design/span_fill_mask_writer.sv
sim/span_fill_mask_writer_tb.sv
